// ===== sv/circ_pkg.sv =====
package circ_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int OUT_FRAC_BITS = 8;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 32;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PR_W   = 2 * DIFF_W;
  localparam int DOT_W  = PR_W + 2;
  localparam int CR_W   = PR_W + 1;
  localparam int W_W    = 2 * DOT_W;
  localparam int SQ_W   = 2 * CR_W;
  localparam int D_W    = SQ_W + 3;
  localparam int WSPLIT = W_W / 2;
  localparam int WLO_W  = WSPLIT + 1;
  localparam int PL_W   = COORD_WIDTH + WLO_W;
  localparam int PH_W   = COORD_WIDTH + W_W - WSPLIT;
  localparam int NUM_W  = COORD_WIDTH + W_W + 2 + OUT_FRAC_BITS;
  localparam int QB     = OUT_W;
  localparam int CMP_W  = (NUM_W > D_W + QB) ? NUM_W : D_W + QB;

  localparam int PREP_STAGES  = 4;
  localparam int NUMER_STAGES = 2;
  localparam int LATENCY      = PREP_STAGES + NUMER_STAGES + QB + 1;

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] a_z;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] b_z;
    logic signed [IN_W-1:0] c_x;
    logic signed [IN_W-1:0] c_y;
    logic signed [IN_W-1:0] c_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic signed [OUT_W-1:0] center_z;
    logic                    degenerate;
    logic                    saturated;
  } out_beat_t;

  typedef struct packed {
    logic vld;
    logic dz;
  } div_ctl_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } ax_flag_t;

  function automatic logic signed [COORD_WIDTH-1:0] coord_of(input logic [IN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return signed'(w[COORD_WIDTH-1:0]);
  endfunction

endpackage

// ===== sv/circ_prep.sv =====
module circ_prep (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  circ_pkg::in_beat_t                    in_data,
  output logic                                  out_vld,
  output logic signed [circ_pkg::PL_W-1:0]      pl_o [3][3],
  output logic signed [circ_pkg::PH_W-1:0]      ph_o [3][3],
  output logic        [circ_pkg::D_W-1:0]       d_o,
  output logic                                  dz_o
);

  localparam int CW     = circ_pkg::COORD_WIDTH;
  localparam int DIFF_W = circ_pkg::DIFF_W;
  localparam int PR_W   = circ_pkg::PR_W;
  localparam int DOT_W  = circ_pkg::DOT_W;
  localparam int CR_W   = circ_pkg::CR_W;
  localparam int W_W    = circ_pkg::W_W;
  localparam int SQ_W   = circ_pkg::SQ_W;
  localparam int D_W    = circ_pkg::D_W;
  localparam int WSPLIT = circ_pkg::WSPLIT;
  localparam int PL_W   = circ_pkg::PL_W;
  localparam int PH_W   = circ_pkg::PH_W;

  function automatic logic signed [DOT_W-1:0] dot3(
    input logic signed [DIFF_W-1:0] u [3],
    input logic signed [DIFF_W-1:0] v [3]
  );
    logic signed [PR_W-1:0] p0, p1, p2;
    p0 = u[0] * v[0];
    p1 = u[1] * v[1];
    p2 = u[2] * v[2];
    return DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);
  endfunction

  function automatic logic signed [CR_W-1:0] crs(
    input logic signed [DIFF_W-1:0] p, q, r, s
  );
    logic signed [PR_W-1:0] t0, t1;
    t0 = p * q;
    t1 = r * s;
    return CR_W'(t0) - CR_W'(t1);
  endfunction

  // stage 1: coordinates and edge vectors
  logic signed [CW-1:0]     co [3][3];
  logic signed [DIFF_W-1:0] ab [3];
  logic signed [DIFF_W-1:0] ac [3];
  logic signed [DIFF_W-1:0] bc [3];
  logic                     v1_r;
  logic signed [CW-1:0]     co1_r [3][3];
  logic signed [DIFF_W-1:0] ab_r [3];
  logic signed [DIFF_W-1:0] ac_r [3];
  logic signed [DIFF_W-1:0] bc_r [3];

  always_comb begin
    co[0][0] = circ_pkg::coord_of(in_data.a_x);
    co[0][1] = circ_pkg::coord_of(in_data.a_y);
    co[0][2] = circ_pkg::coord_of(in_data.a_z);
    co[1][0] = circ_pkg::coord_of(in_data.b_x);
    co[1][1] = circ_pkg::coord_of(in_data.b_y);
    co[1][2] = circ_pkg::coord_of(in_data.b_z);
    co[2][0] = circ_pkg::coord_of(in_data.c_x);
    co[2][1] = circ_pkg::coord_of(in_data.c_y);
    co[2][2] = circ_pkg::coord_of(in_data.c_z);
    for (int ax = 0; ax < 3; ax++) begin
      ab[ax] = DIFF_W'(co[0][ax]) - DIFF_W'(co[1][ax]);
      ac[ax] = DIFF_W'(co[0][ax]) - DIFF_W'(co[2][ax]);
      bc[ax] = DIFF_W'(co[1][ax]) - DIFF_W'(co[2][ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    co1_r <= co;
    ab_r  <= ab;
    ac_r  <= ac;
    bc_r  <= bc;
  end

  // stage 2: dot products and cross product
  logic signed [DOT_W-1:0] dot_nxt [6];
  logic signed [CR_W-1:0]  cr_nxt [3];
  logic                    v2_r;
  logic signed [DOT_W-1:0] dot_r [6];
  logic signed [CR_W-1:0]  cr_r [3];
  logic signed [CW-1:0]    co2_r [3][3];

  always_comb begin
    dot_nxt[0] = dot3(bc_r, bc_r);
    dot_nxt[1] = dot3(ab_r, ac_r);
    dot_nxt[2] = dot3(ac_r, ac_r);
    dot_nxt[3] = -dot3(ab_r, bc_r);
    dot_nxt[4] = dot3(ab_r, ab_r);
    dot_nxt[5] = dot3(ac_r, bc_r);
    cr_nxt[0]  = crs(ab_r[1], bc_r[2], ab_r[2], bc_r[1]);
    cr_nxt[1]  = crs(ab_r[2], bc_r[0], ab_r[0], bc_r[2]);
    cr_nxt[2]  = crs(ab_r[0], bc_r[1], ab_r[1], bc_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dot_r <= dot_nxt;
    cr_r  <= cr_nxt;
    co2_r <= co1_r;
  end

  // stage 3: barycentric weights and squared cross terms
  logic signed [W_W-1:0]  w_nxt [3];
  logic signed [SQ_W-1:0] sq_nxt [3];
  logic                   v3_r;
  logic signed [W_W-1:0]  w_r [3];
  logic signed [SQ_W-1:0] sq_r [3];
  logic signed [CW-1:0]   co3_r [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_nxt[k]  = dot_r[2*k] * dot_r[2*k+1];
      sq_nxt[k] = cr_r[k] * cr_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    sq_r  <= sq_nxt;
    co3_r <= co2_r;
  end

  // stage 4: denominator and split coordinate-weight products
  logic        [D_W-1:0]  d_nxt;
  logic signed [PL_W-1:0] pl_nxt [3][3];
  logic signed [PH_W-1:0] ph_nxt [3][3];
  logic                   v4_r;
  logic        [D_W-1:0]  d_r;
  logic                   dz_r;
  logic signed [PL_W-1:0] pl_r [3][3];
  logic signed [PH_W-1:0] ph_r [3][3];

  always_comb begin
    d_nxt = (D_W'(sq_r[0]) + D_W'(sq_r[1]) + D_W'(sq_r[2])) << 1;
    for (int v = 0; v < 3; v++) begin
      for (int ax = 0; ax < 3; ax++) begin
        pl_nxt[v][ax] = co3_r[v][ax] * signed'({1'b0, w_r[v][WSPLIT-1:0]});
        ph_nxt[v][ax] = co3_r[v][ax] * signed'(w_r[v][W_W-1:WSPLIT]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r  <= d_nxt;
    dz_r <= (d_nxt == '0);
    pl_r <= pl_nxt;
    ph_r <= ph_nxt;
  end

  assign out_vld = v4_r;
  assign pl_o    = pl_r;
  assign ph_o    = ph_r;
  assign d_o     = d_r;
  assign dz_o    = dz_r;

endmodule

// ===== sv/circ_numer.sv =====
module circ_numer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [circ_pkg::PL_W-1:0]  pl_i [3][3],
  input  logic signed [circ_pkg::PH_W-1:0]  ph_i [3][3],
  input  logic        [circ_pkg::D_W-1:0]   d_i,
  input  logic                              dz_i,
  output circ_pkg::div_ctl_t                ctl_o,
  output logic        [circ_pkg::CMP_W-1:0] rem_o [3],
  output circ_pkg::ax_flag_t                fl_o [3],
  output logic        [circ_pkg::D_W-1:0]   d_o
);

  localparam int NUM_W  = circ_pkg::NUM_W;
  localparam int CMP_W  = circ_pkg::CMP_W;
  localparam int D_W    = circ_pkg::D_W;
  localparam int WSPLIT = circ_pkg::WSPLIT;
  localparam int FRAC   = circ_pkg::OUT_FRAC_BITS;
  localparam int QB     = circ_pkg::QB;

  // stage 1: scaled numerator per axis
  logic signed [NUM_W-1:0] num_nxt [3];
  logic                    v1_r;
  logic                    dz1_r;
  logic signed [NUM_W-1:0] num_r [3];
  logic        [D_W-1:0]   d1_r;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      num_nxt[ax] = '0;
      for (int v = 0; v < 3; v++) begin
        num_nxt[ax] = num_nxt[ax] + (NUM_W'(ph_i[v][ax]) <<< WSPLIT) + NUM_W'(pl_i[v][ax]);
      end
      num_nxt[ax] = num_nxt[ax] <<< FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    d1_r  <= d_i;
    dz1_r <= dz_i;
  end

  // stage 2: magnitude, sign and quotient overflow check
  logic [CMP_W-1:0]   mag [3];
  circ_pkg::ax_flag_t fl_nxt [3];
  logic [CMP_W-1:0]   dtop;
  circ_pkg::div_ctl_t ctl_r;
  logic [CMP_W-1:0]   rem_r [3];
  circ_pkg::ax_flag_t fl_r [3];
  logic [D_W-1:0]     d2_r;

  always_comb begin
    dtop = CMP_W'(d1_r) << QB;
    for (int ax = 0; ax < 3; ax++) begin
      fl_nxt[ax].neg = num_r[ax][NUM_W-1];
      mag[ax] = fl_nxt[ax].neg ? CMP_W'(unsigned'(-num_r[ax])) : CMP_W'(unsigned'(num_r[ax]));
      fl_nxt[ax].ovf = (mag[ax] >= dtop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= v1_r;
    end
    ctl_r.dz <= dz1_r;
  end

  always_ff @(posedge clk) begin
    rem_r    <= mag;
    fl_r     <= fl_nxt;
    d2_r     <= d1_r;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign fl_o  = fl_r;
  assign d_o   = d2_r;

endmodule

// ===== sv/circ_div.sv =====
module circ_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  circ_pkg::div_ctl_t                ctl_i,
  input  logic        [circ_pkg::CMP_W-1:0] rem_i [3],
  input  circ_pkg::ax_flag_t                fl_i [3],
  input  logic        [circ_pkg::D_W-1:0]   d_i,
  output circ_pkg::div_ctl_t                ctl_o,
  output logic        [circ_pkg::QB-1:0]    q_o [3],
  output circ_pkg::ax_flag_t                fl_o [3]
);

  localparam int CMP_W = circ_pkg::CMP_W;
  localparam int D_W   = circ_pkg::D_W;
  localparam int QB    = circ_pkg::QB;

  circ_pkg::div_ctl_t ctl_r [1:QB];
  logic [CMP_W-1:0]   rem_r [1:QB][3];
  logic [QB-1:0]      q_r   [1:QB][3];
  circ_pkg::ax_flag_t fl_r  [1:QB][3];
  logic [D_W-1:0]     d_r   [1:QB];

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < QB; s++) begin : g_stg
    circ_pkg::div_ctl_t ctl_in;
    logic [CMP_W-1:0]   rem_in [3];
    logic [QB-1:0]      q_in [3];
    circ_pkg::ax_flag_t fl_in [3];
    logic [D_W-1:0]     d_in;
    logic [CMP_W-1:0]   dsh;
    logic [CMP_W-1:0]   rem_nxt [3];
    logic [QB-1:0]      q_nxt [3];

    if (s == 0) begin : g_first
      always_comb begin
        ctl_in = ctl_i;
        d_in   = d_i;
        for (int ax = 0; ax < 3; ax++) begin
          rem_in[ax] = rem_i[ax];
          q_in[ax]   = '0;
          fl_in[ax]  = fl_i[ax];
        end
      end
    end else begin : g_next
      always_comb begin
        ctl_in = ctl_r[s];
        d_in   = d_r[s];
        for (int ax = 0; ax < 3; ax++) begin
          rem_in[ax] = rem_r[s][ax];
          q_in[ax]   = q_r[s][ax];
          fl_in[ax]  = fl_r[s][ax];
        end
      end
    end

    always_comb begin
      logic ge;
      dsh = CMP_W'(d_in) << (QB - 1 - s);
      for (int ax = 0; ax < 3; ax++) begin
        ge          = (rem_in[ax] >= dsh);
        rem_nxt[ax] = ge ? rem_in[ax] - dsh : rem_in[ax];
        q_nxt[ax]   = {q_in[ax][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1].vld <= 1'b0;
      end else begin
        ctl_r[s+1].vld <= ctl_in.vld;
      end
      ctl_r[s+1].dz <= ctl_in.dz;
    end

    always_ff @(posedge clk) begin
      d_r[s+1]      <= d_in;
      for (int ax = 0; ax < 3; ax++) begin
        rem_r[s+1][ax] <= rem_nxt[ax];
        q_r[s+1][ax]   <= q_nxt[ax];
        fl_r[s+1][ax]  <= fl_in[ax];
      end
    end
  end

  assign ctl_o = ctl_r[QB];
  assign q_o   = q_r[QB];
  assign fl_o  = fl_r[QB];

endmodule

// ===== sv/triangle_circumcenter_3d_unit.sv =====
// throughput: one triangle per cycle, busy stays low, results cannot be held off
// the rate is set by a fully pipelined datapath: 4 product stages, 2 numerator
// stages, one restoring divide step per stage over 32 quotient bits, 1 output stage
// reset: synchronous active-low rst_n clears all valid bits; no clearing pass
module triangle_circumcenter_3d_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  circ_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output circ_pkg::out_beat_t out_data
);

  localparam int PL_W  = circ_pkg::PL_W;
  localparam int PH_W  = circ_pkg::PH_W;
  localparam int D_W   = circ_pkg::D_W;
  localparam int CMP_W = circ_pkg::CMP_W;
  localparam int QB    = circ_pkg::QB;
  localparam int OUT_W = circ_pkg::OUT_W;

  logic                   accept;
  logic                   p_vld;
  logic signed [PL_W-1:0] pl [3][3];
  logic signed [PH_W-1:0] ph [3][3];
  logic        [D_W-1:0]  p_d;
  logic                   p_dz;
  circ_pkg::div_ctl_t     n_ctl;
  logic [CMP_W-1:0]       n_rem [3];
  circ_pkg::ax_flag_t     n_fl [3];
  logic [D_W-1:0]         n_d;
  circ_pkg::div_ctl_t     q_ctl;
  logic [QB-1:0]          q [3];
  circ_pkg::ax_flag_t     q_fl [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  circ_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_data (in_data),
    .out_vld (p_vld),
    .pl_o    (pl),
    .ph_o    (ph),
    .d_o     (p_d),
    .dz_o    (p_dz)
  );

  circ_numer u_numer (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (p_vld),
    .pl_i   (pl),
    .ph_i   (ph),
    .d_i    (p_d),
    .dz_i   (p_dz),
    .ctl_o  (n_ctl),
    .rem_o  (n_rem),
    .fl_o   (n_fl),
    .d_o    (n_d)
  );

  circ_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (n_ctl),
    .rem_i (n_rem),
    .fl_i  (n_fl),
    .d_i   (n_d),
    .ctl_o (q_ctl),
    .q_o   (q),
    .fl_o  (q_fl)
  );

  // sign, clamp and degenerate handling
  logic signed [OUT_W-1:0] cen [3];
  logic                    sat_ax [3];
  logic                    out_valid_r;
  circ_pkg::out_beat_t     out_nxt;
  circ_pkg::out_beat_t     out_r;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      if (q_ctl.dz) begin
        sat_ax[ax] = 1'b0;
        cen[ax]    = '0;
      end else if (!q_fl[ax].neg) begin
        sat_ax[ax] = q_fl[ax].ovf || q[ax][QB-1];
        cen[ax]    = sat_ax[ax] ? signed'({1'b0, {(OUT_W-1){1'b1}}}) : signed'(OUT_W'(q[ax]));
      end else begin
        sat_ax[ax] = q_fl[ax].ovf || (q[ax][QB-1] && (q[ax][QB-2:0] != '0));
        cen[ax]    = sat_ax[ax] ? signed'({1'b1, {(OUT_W-1){1'b0}}})
                                : signed'(OUT_W'(-q[ax]));
      end
    end
    out_nxt.center_x   = cen[0];
    out_nxt.center_y   = cen[1];
    out_nxt.center_z   = cen[2];
    out_nxt.degenerate = q_ctl.dz;
    out_nxt.saturated  = sat_ax[0] || sat_ax[1] || sat_ax[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_degen_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.degenerate |->
      !out_r.saturated && out_r.center_x == '0 && out_r.center_y == '0 && out_r.center_z == '0)
    else $error("degenerate beat with nonzero payload");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept, circ_pkg::LATENCY))
    else $error("result beat without matching start beat");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    $past(q_ctl.vld) |-> out_valid_r)
    else $error("divider beat dropped at output");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule
